// File: design/timed_window_sample_statistics_macros.svh
// Assertion macros shared by the checker of the timed window statistics block.
// Depends on nothing; included by the checker file only.
`ifndef TIMED_WINDOW_SAMPLE_STATISTICS_MACROS_SVH
`define TIMED_WINDOW_SAMPLE_STATISTICS_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define TWS_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TWS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

// File: design/tws_pkg.sv
// Package of the timed window statistics block: request codes and the
// controller-to-datapath command and status structs. Depends on nothing.
package tws_pkg;
  localparam logic [2:0] REQ_APPEND = 3'd0;
  localparam logic [2:0] REQ_SMOOTH = 3'd1;
  localparam logic [2:0] REQ_MIN    = 3'd2;
  localparam logic [2:0] REQ_MAX    = 3'd3;
  localparam logic [2:0] REQ_DELTA  = 3'd4;
  localparam logic [2:0] REQ_CLEAR  = 3'd5;

  typedef struct packed {
    logic append;     // write the captured sample into the ring
    logic clear;      // empty the ring
    logic start;      // capture the request and reset the accumulators
    logic rd_issue;   // read the next older slot
    logic accum;      // fold the returned entry into the statistics
    logic div_start;  // launch the divider
    logic finish;     // form the result into the output register
  } tws_cmd_t;

  typedef struct packed {
    logic walk_last;  // no more entries to read
    logic entry_out;  // returned entry lies before the window start
    logic div_busy;
  } tws_sts_t;
endpackage

// File: design/tws_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
module tws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: design/tws_div.sv
// Restoring divider, one quotient bit a cycle, signed dividend, positive divisor.
// Depends on nothing.
module tws_div #(
  parameter int NW = 34,
  parameter int DW = 13
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NW-1:0] dividend,
  input  logic [DW-1:0]        divisor,
  output logic                 busy,
  output logic signed [NW-1:0] quotient
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] dsr_r;
  logic          neg_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [DW:0]   trial;

  always_comb begin
    trial   = {rem_r[DW-1:0], q_r[NW-1]};
    q_nxt   = {q_r[NW-2:0], 1'b0};
    rem_nxt = trial;
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt  = trial - {1'b0, dsr_r};
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NW);
      neg_r  <= dividend[NW-1];
      q_r    <= dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
      rem_r  <= '0;
      dsr_r  <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy     = busy_r;
  assign quotient = neg_r ? -$signed(q_r) : $signed(q_r);
endmodule

// File: design/tws_datapath.sv
// Datapath: sample ring memories, pointers, window walk accumulators,
// divider and output register. Depends on tws_pkg, tws_ram and tws_div.
module tws_datapath #(
  parameter int RING_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tws_pkg::tws_cmd_t   cmd,
  output tws_pkg::tws_sts_t   sts,
  input  logic [2:0]          in_req_type,
  input  logic signed [23:0]  in_sample_value,
  input  logic [31:0]         in_sample_time_ms,
  input  logic [15:0]         in_window_ms,
  input  logic [31:0]         in_now_ms,
  output logic signed [24:0]  res_value,
  output logic [31:0]         res_span_ms,
  output logic [8:0]          res_window_count,
  output logic                res_delta_valid
);
  import tws_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int FW = $clog2(RING_DEPTH + 1);
  localparam int SW = 24 + FW + 1;

  logic [AW-1:0] wp_r;
  logic [FW-1:0] fill_r;
  logic [AW-1:0] rd_addr_r;
  logic [FW-1:0] issued_r;
  logic [FW-1:0] n_r;
  logic [2:0]    req_r;
  logic [31:0]   start_r;
  logic signed [23:0] cap_v_r;
  logic [31:0]        cap_t_r;
  logic signed [SW-1:0] sum_r;
  logic signed [23:0] mn_r, mx_r, newest_v_r, oldest_v_r;
  logic [31:0]        newest_t_r, oldest_t_r;
  logic               stopped_r;

  logic [AW-1:0]      addr;
  logic signed [23:0] rd_v;
  logic [31:0]        rd_t;
  logic               we;
  logic               div_busy;
  logic signed [SW-1:0] quot;
  logic signed [SW-1:0] trimmed;
  logic [FW-1:0]      n_minus2;

  assign we   = cmd.append;
  assign addr = cmd.append ? wp_r : rd_addr_r;

  tws_ram #(.WIDTH(24), .DEPTH(RING_DEPTH)) u_val (
    .clk(clk), .we(we), .addr(addr), .wdata(cap_v_r), .rdata(rd_v));
  tws_ram #(.WIDTH(32), .DEPTH(RING_DEPTH)) u_time (
    .clk(clk), .we(we), .addr(addr), .wdata(cap_t_r), .rdata(rd_t));

  assign trimmed  = sum_r - SW'(mn_r) - SW'(mx_r);
  assign n_minus2 = n_r - FW'(2);

  tws_div #(.NW(SW), .DW(FW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(trimmed),
    .divisor(n_minus2), .busy(div_busy), .quotient(quot));

  assign sts.walk_last = (issued_r == fill_r);
  assign sts.entry_out = (rd_t < start_r);
  assign sts.div_busy  = div_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
    end else if (cmd.clear) begin
      wp_r   <= '0;
      fill_r <= '0;
    end else if (cmd.append) begin
      wp_r <= (wp_r == AW'(RING_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (fill_r != FW'(RING_DEPTH)) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_r     <= in_req_type;
      cap_v_r   <= in_sample_value;
      cap_t_r   <= in_sample_time_ms;
      start_r   <= in_now_ms - {16'd0, in_window_ms};
      rd_addr_r <= (wp_r == '0) ? AW'(RING_DEPTH - 1) : wp_r - 1'b1;
      issued_r  <= '0;
      n_r       <= '0;
      sum_r     <= '0;
      stopped_r <= 1'b0;
    end
    if (cmd.rd_issue) begin
      rd_addr_r <= (rd_addr_r == '0) ? AW'(RING_DEPTH - 1) : rd_addr_r - 1'b1;
      issued_r  <= issued_r + 1'b1;
    end
    if (cmd.accum) begin
      // The first read also gives the newest sample for an empty window.
      if (issued_r == FW'(1) && sts.entry_out) begin
        newest_v_r <= rd_v;
      end
      if (!stopped_r && !sts.entry_out) begin
        if (n_r == '0) begin
          newest_v_r <= rd_v;
          newest_t_r <= rd_t;
          mn_r <= rd_v;
          mx_r <= rd_v;
        end else begin
          if (rd_v < mn_r) mn_r <= rd_v;
          if (rd_v > mx_r) mx_r <= rd_v;
        end
        oldest_v_r <= rd_v;
        oldest_t_r <= rd_t;
        sum_r      <= sum_r + SW'(rd_v);
        n_r        <= n_r + 1'b1;
      end else begin
        stopped_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_value        <= '0;
      res_span_ms      <= '0;
      res_delta_valid  <= 1'b0;
      res_window_count <= (FW > 9 && n_r > FW'(511)) ? 9'd511 : 9'(n_r);
      unique case (req_r)
        REQ_SMOOTH: begin
          if (n_r == '0) begin
            res_value <= (fill_r == '0) ? '0 : 25'(newest_v_r);
          end else if (n_r == FW'(1)) begin
            res_value <= 25'(newest_v_r);
          end else if (n_r == FW'(2)) begin
            res_value <= 25'((sum_r + SW'(sum_r[SW-1])) >>> 1);
          end else begin
            res_value <= 25'(quot);
          end
        end
        REQ_MIN: res_value <= (n_r == '0) ? '0 : 25'(mn_r);
        REQ_MAX: res_value <= (n_r == '0) ? '0 : 25'(mx_r);
        REQ_DELTA: begin
          if (fill_r >= FW'(2) && n_r >= FW'(2)) begin
            res_value       <= 25'(newest_v_r) - 25'(oldest_v_r);
            res_span_ms     <= newest_t_r - oldest_t_r;
            res_delta_valid <= 1'b1;
          end
          if (fill_r < FW'(2)) begin
            res_window_count <= '0;
          end
        end
        default: res_value <= '0;
      endcase
    end
  end
endmodule

// File: design/tws_ctrl.sv
// Controller of the timed window statistics block: request decode, walk
// sequencing and the result handshake. Depends on tws_pkg.
module tws_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_req_type,
  output logic              out_valid,
  input  logic              out_stall,
  output tws_pkg::tws_cmd_t cmd,
  input  tws_pkg::tws_sts_t sts
);
  import tws_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_APPEND, ST_WALK, ST_DIV_GO, ST_DIV, ST_DONE
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   pend_r;     // a read is in flight and returns next cycle
  logic   accept;

  // A new item is taken while a finished result still waits.
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    cmd.start = accept;
    cmd.clear = accept && (in_req_type == REQ_CLEAR);
    cmd.append = (state_r == ST_APPEND);
    cmd.accum  = (state_r == ST_WALK) && pend_r;
    cmd.rd_issue = (state_r == ST_WALK) && !sts.walk_last
                   && !(pend_r && sts.entry_out);
    cmd.div_start = (state_r == ST_DIV_GO);
    cmd.finish = (state_r == ST_DONE) && !(out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          pend_r <= 1'b0;
          if (accept) begin
            case (in_req_type)
              REQ_APPEND: state_r <= ST_APPEND;
              REQ_SMOOTH, REQ_MIN, REQ_MAX, REQ_DELTA: state_r <= ST_WALK;
              default: state_r <= ST_IDLE;
            endcase
          end
        end
        ST_APPEND: state_r <= ST_IDLE;
        ST_WALK: begin
          pend_r <= cmd.rd_issue;
          // The walk ends at the first entry before the window start, or when no entry is left to read.
          if ((!cmd.rd_issue && !pend_r) || (pend_r && sts.entry_out)) begin
            state_r <= ST_DIV_GO;
          end
        end
        ST_DIV_GO: state_r <= ST_DIV;
        ST_DIV: begin
          if (!sts.div_busy) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (cmd.finish) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule

// File: design/timed_window_sample_statistics.sv
// Top level of the timed window sample statistics block.
// Depends on tws_pkg, tws_ctrl and tws_datapath.
//
// Keeps a ring of RING_DEPTH timestamped 24-bit samples in two single-port
// RAMs. Appends and clears give no result. A query walks from the newest
// sample towards the oldest, one RAM read a cycle, stopping at the first
// sample older than now minus window or at the oldest stored sample; it then
// runs a bit-serial divider. One item is in work at a time; a finished result
// waits in the output register.
module timed_window_sample_statistics #(
  parameter int RING_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_req_type,
  input  logic signed [23:0] in_sample_value,
  input  logic [31:0]        in_sample_time_ms,
  input  logic [15:0]        in_window_ms,
  input  logic [31:0]        in_now_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [24:0] out_result_value,
  output logic [31:0]        out_span_ms,
  output logic [8:0]         out_window_count,
  output logic               out_delta_valid
);
  import tws_pkg::*;

  tws_cmd_t cmd;
  tws_sts_t sts;

  tws_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd), .sts(sts));

  tws_datapath #(.RING_DEPTH(RING_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_req_type(in_req_type), .in_sample_value(in_sample_value),
    .in_sample_time_ms(in_sample_time_ms), .in_window_ms(in_window_ms),
    .in_now_ms(in_now_ms), .res_value(out_result_value),
    .res_span_ms(out_span_ms), .res_window_count(out_window_count),
    .res_delta_valid(out_delta_valid));
endmodule

// File: design/tws_checker.sv
// Port-level checker of the timed window statistics block and its binding.
// Depends on timed_window_sample_statistics_macros.svh.
`include "timed_window_sample_statistics_macros.svh"
module tws_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [24:0] out_result_value,
  input logic [31:0] out_span_ms,
  input logic        out_delta_valid
);
  `TWS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `TWS_ASSERT_IMP(a_delta_zero, clk, rst_n, out_valid && !out_delta_valid, out_span_ms == 32'd0)
  `TWS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_result_value))
endmodule

bind timed_window_sample_statistics tws_checker u_tws_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_result_value(out_result_value), .out_span_ms(out_span_ms),
  .out_delta_valid(out_delta_valid));

// File: tb/tb_timed_window_sample_statistics.sv
// Self-checking testbench of the timed window sample statistics block.
// Depends on tws_pkg and timed_window_sample_statistics; a built-in model of
// the sample ring predicts each query result, checked in arrival order.
module tb_timed_window_sample_statistics;
  timeunit 1ns;
  timeprecision 1ps;
  import tws_pkg::*;

  localparam int DEPTH = 256;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    logic signed [24:0] value;
    logic [31:0]        span;
    logic [8:0]         count;
    logic               dv;
  } stats_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_req_type;
  logic signed [23:0] in_sample_value;
  logic [31:0]        in_sample_time_ms;
  logic [15:0]        in_window_ms;
  logic [31:0]        in_now_ms;
  logic               out_valid;
  logic               out_stall;
  logic signed [24:0] out_result_value;
  logic [31:0]        out_span_ms;
  logic [8:0]         out_window_count;
  logic               out_delta_valid;

  timed_window_sample_statistics dut (.*);

  // Model of the ring.
  logic signed [23:0] ring_value [DEPTH];
  logic [31:0]        ring_time [DEPTH];
  int unsigned        ring_wp;
  int unsigned        ring_fill;

  stats_t      pending_stats[$];
  int          error_count;
  int          idle_cycles;
  bit          hold_request;
  int          burst_left;
  logic [31:0] clock_ms;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Works out the statistics of one accepted item; returns 1 if it has a result.
  function automatic bit model_request(input logic [2:0] req, input logic signed [23:0] sval,
                                       input logic [31:0] stime, input logic [15:0] win,
                                       input logic [31:0] now, output stats_t r);
    logic [31:0] wstart;
    logic [31:0] t;
    logic [31:0] newest_t;
    logic [31:0] oldest_t;
    longint x;
    longint sum;
    longint mn;
    longint mx;
    longint newest_v;
    longint oldest_v;
    longint res;
    int unsigned n;
    int unsigned s;
    r = '{default: '0};
    if (req == REQ_APPEND) begin
      ring_value[ring_wp] = sval;
      ring_time[ring_wp] = stime;
      ring_wp = (ring_wp + 1) % DEPTH;
      if (ring_fill < DEPTH) ring_fill++;
      return 1'b0;
    end
    if (req == REQ_CLEAR) begin
      ring_wp = 0;
      ring_fill = 0;
      return 1'b0;
    end
    if (req > REQ_CLEAR) return 1'b0;
    if (req == REQ_DELTA && ring_fill < 2) return 1'b1;
    wstart = now - 32'(win);
    n = 0; sum = 0; mn = 0; mx = 0; newest_v = 0; oldest_v = 0;
    newest_t = '0; oldest_t = '0;
    for (int i = 0; i < ring_fill; i++) begin
      s = (ring_wp + 2 * DEPTH - 1 - i) % DEPTH;
      x = ring_value[s];
      t = ring_time[s];
      if (t < wstart) break;
      if (n == 0) begin
        newest_v = x; newest_t = t; mn = x; mx = x;
      end
      if (x < mn) mn = x;
      if (x > mx) mx = x;
      oldest_v = x;
      oldest_t = t;
      sum += x;
      n++;
    end
    r.count = 9'(n);
    case (req)
      REQ_SMOOTH: begin
        if (n == 0) res = ring_fill ? longint'(ring_value[(ring_wp + DEPTH - 1) % DEPTH]) : 0;
        else if (n == 1) res = newest_v;
        else if (n == 2) res = sum / 2;
        else res = (sum - mn - mx) / longint'(n - 2);
        r.value = 25'(res);
      end
      REQ_MIN: r.value = 25'(mn);
      REQ_MAX: r.value = 25'(mx);
      default: begin
        if (n >= 2) begin
          r.value = 25'(newest_v - oldest_v);
          r.span = newest_t - oldest_t;
          r.dv = 1'b1;
        end
      end
    endcase
    return 1'b1;
  endfunction

  // Sends one item, in bursts with random gaps, and predicts on acceptance.
  task automatic send_item(input logic [2:0] req, input logic signed [23:0] sval,
                           input logic [31:0] stime, input logic [15:0] win,
                           input logic [31:0] now);
    stats_t r;
    if (burst_left == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end else begin
      @(negedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_req_type <= req;
    in_sample_value <= sval;
    in_sample_time_ms <= stime;
    in_window_ms <= win;
    in_now_ms <= now;
    do @(posedge clk); while (in_stall);
    if (model_request(req, sval, stime, win, now, r)) pending_stats.push_back(r);
  endtask

  task automatic append_at(input logic signed [23:0] sval, input logic [31:0] stime);
    send_item(REQ_APPEND, sval, stime, '0, '0);
  endtask

  task automatic query(input logic [2:0] req, input logic [15:0] win, input logic [31:0] now);
    send_item(req, 24'($urandom()), $urandom(), win, now);
  endtask

  task automatic test_empty_ring();
    query(REQ_SMOOTH, 16'hFFFF, 32'hFFFF_FFFF);
    query(REQ_MIN, 16'd0, 32'd0);
    query(REQ_MAX, 16'd100, 32'd50);
    query(REQ_DELTA, 16'hFFFF, 32'hFFFF_FFFF);
    // Unused codes must be swallowed without a result.
    send_item(3'd6, 24'h7FFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(3'd7, 24'h800000, 32'h0, 16'h0, 32'h0);
  endtask

  task automatic test_extremes_and_wrap();
    append_at(24'sh7FFFFF, 32'hFFFF_FFF0);
    query(REQ_DELTA, 16'hFFFF, 32'hFFFF_FFFF);
    query(REQ_SMOOTH, 16'd0, 32'hFFFF_FFF0);
    append_at(-24'sd8388608, 32'hFFFF_FFF8);
    query(REQ_SMOOTH, 16'd8, 32'hFFFF_FFF8);
    query(REQ_DELTA, 16'hFFFF, 32'hFFFF_FFFF);
    append_at(24'sd0, 32'hFFFF_FFFF);
    query(REQ_SMOOTH, 16'hFFFF, 32'hFFFF_FFFF);
    query(REQ_MIN, 16'hFFFF, 32'hFFFF_FFFF);
    query(REQ_MAX, 16'hFFFF, 32'hFFFF_FFFF);
    query(REQ_DELTA, 16'd0, 32'hFFFF_FFFF);
    // Window start wraps below zero to a large value, so only the two newest stored times lie inside it.
    query(REQ_MAX, 16'd20, 32'd5);
    // Window start lies below every stored time, so all samples count as inside it.
    query(REQ_SMOOTH, 16'd0, 32'd3);
    query(REQ_MIN, 16'd0, 32'd3);
    send_item(REQ_CLEAR, '0, '0, '0, '0);
    query(REQ_SMOOTH, 16'hFFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_full_ring();
    clock_ms = 32'd1000;
    for (int i = 0; i < 300; i++) begin
      clock_ms += $urandom_range(0, 3);
      append_at(24'($urandom()), clock_ms);
    end
    query(REQ_SMOOTH, 16'hFFFF, clock_ms);
    query(REQ_MIN, 16'hFFFF, clock_ms);
    query(REQ_MAX, 16'hFFFF, clock_ms);
    query(REQ_DELTA, 16'hFFFF, clock_ms);
    query(REQ_DELTA, 16'd40, clock_ms);
  endtask

  task automatic test_backpressure();
    hold_request = 1'b1;
    for (int i = 0; i < 12; i++) query(3'($urandom_range(1, 4)), 16'($urandom_range(0, 600)),
                                       clock_ms);
    hold_request = 1'b0;
  endtask

  task automatic test_random_traffic();
    int pick;
    logic signed [23:0] sval;
    for (int i = 0; i < 370; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
        clock_ms += $urandom_range(0, 40);
        sval = ($urandom_range(0, 15) == 0) ? ($urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000)
                                            : 24'($urandom());
        append_at(sval, clock_ms);
      end else if (pick < 95) begin
        query(3'($urandom_range(1, 4)),
              ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 800)),
              ($urandom_range(0, 9) == 0) ? 32'($urandom()) : clock_ms + $urandom_range(0, 100));
      end else if (pick < 97) begin
        send_item(REQ_CLEAR, 24'($urandom()), $urandom(), 16'($urandom()), $urandom());
      end else begin
        send_item(3'($urandom_range(6, 7)), 24'($urandom()), $urandom(), 16'($urandom()),
                  $urandom());
      end
    end
  endtask

  // Receiver stall pattern, with a long hold-off on request.
  initial begin
    int mode_left;
    bit stalling;
    out_stall = 1'b0;
    mode_left = 0;
    stalling = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        wait (!hold_request);
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(16, 96);
          stalling = $urandom_range(0, 2) != 0;
        end
        mode_left--;
        out_stall <= stalling && ($urandom_range(0, 2) == 0);
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    stats_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_stats.size() == 0) begin
        $error("result with no pending query: value %0d", out_result_value);
        error_count++;
      end else begin
        e = pending_stats.pop_front();
        if (out_result_value !== e.value) begin
          $error("result_value: expected %0d, got %0d", e.value, out_result_value);
          error_count++;
        end
        if (out_span_ms !== e.span) begin
          $error("span_ms: expected %0d, got %0d", e.span, out_span_ms);
          error_count++;
        end
        if (out_window_count !== e.count) begin
          $error("window_count: expected %0d, got %0d", e.count, out_window_count);
          error_count++;
        end
        if (out_delta_valid !== e.dv) begin
          $error("delta_valid: expected %0d, got %0d", e.dv, out_delta_valid);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no item moving on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_timed_window_sample_statistics: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_APPEND;
    in_sample_value = '0;
    in_sample_time_ms = '0;
    in_window_ms = '0;
    in_now_ms = '0;
    error_count = 0;
    hold_request = 1'b0;
    burst_left = 0;
    clock_ms = '0;
    ring_wp = 0;
    ring_fill = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_ring();
    test_extremes_and_wrap();
    test_full_ring();
    test_backpressure();
    test_random_traffic();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_stats.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_timed_window_sample_statistics: PASS");
    end else begin
      $display("tb_timed_window_sample_statistics: FAIL");
    end
    $finish;
  end
endmodule
